// ===== hw/rtl/spls_pkg.sv =====
// ----------------------------------------------------------------------------
// spls_pkg
// Shared types, widths and solve sequence for the similarity pose fit.
// ----------------------------------------------------------------------------
package spls_pkg;

  localparam int COORD_W = 16;
  localparam int CNT_W   = 11;
  localparam int SUM_W   = 26;
  localparam int XP_W    = 42;
  localparam int RAD_W   = 43;
  localparam int WRK_W   = 64;
  localparam int RES_W   = 32;
  localparam int PC_W    = 5;
  localparam logic [CNT_W-1:0] PAIR_CAP = 11'd1024;

  typedef enum logic [2:0] {S_ACC, S_SETTLE, S_RUN, S_DIV, S_OUT} state_t;

  typedef enum logic [1:0] {K_MUL, K_CHECK, K_DIV, K_END} ukind_t;

  typedef enum logic [3:0] {
    P_NONE, P_N_SR, P_SX_SX, P_SY_SY, P_N_XUYV, P_SX_SU, P_SY_SV, P_N_XVYU,
    P_SY_SU, P_SX_SV, P_SU_SH, P_SV_SH, P_A_SX, P_B_SY, P_A_SY, P_B_SX
  } psel_t;

  typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_ADD, OP_SUB} aop_t;
  typedef enum logic [1:0] {W_DEN, W_NA, W_NB, W_T} wsel_t;
  typedef enum logic [1:0] {D_A, D_B, D_TX, D_TY} dsel_t;

  typedef struct packed {
    ukind_t kind;
    psel_t  psel;
    aop_t   op;
    wsel_t  dst;
    dsel_t  dsel;
  } uop_t;

  typedef struct packed {
    logic   acc_fire;
    logic   clear;
    logic   mul;
    psel_t  psel;
    aop_t   op;
    wsel_t  dst;
    logic   div_start;
    dsel_t  dsel;
    logic   chk;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
  } sts_t;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{K_MUL,   P_N_SR,   OP_LOAD, W_DEN, D_A};
      5'd1:  u = '{K_MUL,   P_SX_SX,  OP_SUB,  W_DEN, D_A};
      5'd2:  u = '{K_MUL,   P_SY_SY,  OP_SUB,  W_DEN, D_A};
      5'd3:  u = '{K_MUL,   P_N_XUYV, OP_LOAD, W_NA,  D_A};
      5'd4:  u = '{K_MUL,   P_SX_SU,  OP_SUB,  W_NA,  D_A};
      5'd5:  u = '{K_MUL,   P_SY_SV,  OP_SUB,  W_NA,  D_A};
      5'd6:  u = '{K_MUL,   P_N_XVYU, OP_LOAD, W_NB,  D_A};
      5'd7:  u = '{K_MUL,   P_SY_SU,  OP_ADD,  W_NB,  D_A};
      5'd8:  u = '{K_MUL,   P_SX_SV,  OP_SUB,  W_NB,  D_A};
      5'd9:  u = '{K_MUL,   P_NONE,   OP_NONE, W_DEN, D_A};
      5'd10: u = '{K_CHECK, P_NONE,   OP_NONE, W_DEN, D_A};
      5'd11: u = '{K_DIV,   P_NONE,   OP_NONE, W_DEN, D_A};
      5'd12: u = '{K_DIV,   P_NONE,   OP_NONE, W_DEN, D_B};
      5'd13: u = '{K_MUL,   P_SU_SH,  OP_LOAD, W_T,   D_A};
      5'd14: u = '{K_MUL,   P_A_SX,   OP_SUB,  W_T,   D_A};
      5'd15: u = '{K_MUL,   P_B_SY,   OP_ADD,  W_T,   D_A};
      5'd16: u = '{K_MUL,   P_NONE,   OP_NONE, W_T,   D_A};
      5'd17: u = '{K_DIV,   P_NONE,   OP_NONE, W_T,   D_TX};
      5'd18: u = '{K_MUL,   P_SV_SH,  OP_LOAD, W_T,   D_A};
      5'd19: u = '{K_MUL,   P_A_SY,   OP_SUB,  W_T,   D_A};
      5'd20: u = '{K_MUL,   P_B_SX,   OP_SUB,  W_T,   D_A};
      5'd21: u = '{K_MUL,   P_NONE,   OP_NONE, W_T,   D_A};
      5'd22: u = '{K_DIV,   P_NONE,   OP_NONE, W_T,   D_TY};
      default: u = '{K_END, P_NONE,   OP_NONE, W_DEN, D_A};
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/spls_div.sv =====
// ----------------------------------------------------------------------------
// spls_div
// Radix-2 restoring divider, rounded to nearest and saturated to 32 bits.
// ----------------------------------------------------------------------------
module spls_div import spls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    frac16,
  input  logic signed [WRK_W-1:0] num,
  input  logic signed [WRK_W-1:0] den,
  output logic                    done,
  output logic signed [RES_W-1:0] quo
);

  localparam int DVD_W = 80;
  localparam int CNT_DW = 7;
  localparam logic [CNT_DW-1:0] LAST_IT = CNT_DW'(DVD_W - 1);

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [WRK_W-1:0]  rem_r, rem_nxt;
  logic [WRK_W-1:0]  d_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_DW-1:0] cnt_r;

  logic [WRK_W-1:0]  num_mag, den_mag;
  logic [DVD_W-1:0]  dvd_init;
  logic [WRK_W:0]    sh, dif;
  logic              ge;
  logic              ovf;
  logic [RES_W+1:0]  r34;
  logic [RES_W:0]    rq;

  assign num_mag  = num[WRK_W-1] ? WRK_W'(-num) : WRK_W'(num);
  assign den_mag  = den[WRK_W-1] ? WRK_W'(-den) : WRK_W'(den);
  assign dvd_init = frac16 ? ({(DVD_W-WRK_W)'(0), num_mag} << 17)
                           : ({(DVD_W-WRK_W)'(0), num_mag} << 1);

  assign sh  = {rem_r, dvd_r[DVD_W-1]};
  assign dif = sh - {1'b0, d_r};
  assign ge  = (sh >= {1'b0, d_r});
  assign rem_nxt = ge ? dif[WRK_W-1:0] : sh[WRK_W-1:0];
  assign dvd_nxt = {dvd_r[DVD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_IT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd_init;
      rem_r <= '0;
      d_r   <= den_mag;
      neg_r <= num[WRK_W-1] ^ den[WRK_W-1];
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  // round half away from zero, then clamp
  assign ovf = |dvd_r[DVD_W-1:RES_W+1];
  assign r34 = {1'b0, dvd_r[RES_W:0]} + (RES_W+2)'(1);
  assign rq  = r34[RES_W+1:1];

  always_comb begin
    if (neg_r) begin
      if (ovf || rq[RES_W] || rq[RES_W-1]) quo = {1'b1, {(RES_W-1){1'b0}}};
      else quo = -$signed(rq[RES_W-1:0]);
    end else begin
      if (ovf || rq[RES_W] || rq[RES_W-1]) quo = {1'b0, {(RES_W-1){1'b1}}};
      else quo = $signed(rq[RES_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

// ===== hw/rtl/spls_dp.sv =====
// ----------------------------------------------------------------------------
// spls_dp
// Datapath: running sums, shared multipliers, work registers and divider.
// ----------------------------------------------------------------------------
module spls_dp import spls_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  input  logic signed [COORD_W-1:0] in_model_x,
  input  logic signed [COORD_W-1:0] in_model_y,
  input  logic signed [COORD_W-1:0] in_target_x,
  input  logic signed [COORD_W-1:0] in_target_y,
  output sts_t                      sts,
  output logic signed [RES_W-1:0]   res_scale_cos,
  output logic signed [RES_W-1:0]   res_scale_sin,
  output logic signed [RES_W-1:0]   res_shift_x,
  output logic signed [RES_W-1:0]   res_shift_y,
  output logic                      res_degenerate,
  output logic [CNT_W-1:0]          res_pairs_used
);

  // product stage
  logic signed [2*COORD_W-1:0] p_x_r, p_y_r, p_u_r, p_v_r;
  logic signed [2*COORD_W-1:0] p_xu_r, p_yv_r, p_xv_r, p_yu_r;
  logic signed [2*COORD_W:0]   p_rr_r;
  logic                        add_en_r;

  // sums
  logic signed [SUM_W-1:0] sx_r, sy_r, su_r, sv_r;
  logic signed [XP_W-1:0]  sxu_r, syv_r, sxv_r, syu_r;
  logic signed [RAD_W-1:0] sr_r;
  logic [CNT_W-1:0]        cnt_r;

  // solve
  logic signed [WRK_W-1:0] den_r, na_r, nb_r, t_r, prod_r, prod_nxt, wr_val, wr_old;
  aop_t                    pend_op_r;
  wsel_t                   pend_dst_r;
  logic signed [RES_W-1:0] a_r, b_r, tx_r, ty_r;
  logic                    degen_r;
  dsel_t                   dsel_r;

  logic signed [CNT_W:0]   n_s;
  logic signed [RAD_W:0]   sm_op;
  logic signed [RAD_W+CNT_W+1:0] sm_prod;
  logic signed [RES_W:0]   bg_a, bg_b;
  logic signed [2*RES_W+1:0] bg_prod;
  logic                    use_small, use_shift;
  logic signed [WRK_W-1:0] sh_val;

  logic signed [WRK_W-1:0] d_num, d_den;
  logic                    d_frac16;
  logic                    d_done;
  logic signed [RES_W-1:0] d_quo;

  // accumulate: products, then sums
  always_ff @(posedge clk) begin
    if (cmd.acc_fire) begin
      p_x_r  <= (2*COORD_W)'(in_model_x);
      p_y_r  <= (2*COORD_W)'(in_model_y);
      p_u_r  <= (2*COORD_W)'(in_target_x);
      p_v_r  <= (2*COORD_W)'(in_target_y);
      p_xu_r <= in_model_x * in_target_x;
      p_yv_r <= in_model_y * in_target_y;
      p_xv_r <= in_model_x * in_target_y;
      p_yu_r <= in_model_y * in_target_x;
      p_rr_r <= (2*COORD_W+1)'(in_model_x) * (2*COORD_W+1)'(in_model_x)
              + (2*COORD_W+1)'(in_model_y) * (2*COORD_W+1)'(in_model_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      add_en_r <= 1'b0;
      cnt_r    <= '0;
      sx_r <= '0; sy_r <= '0; su_r <= '0; sv_r <= '0;
      sxu_r <= '0; syv_r <= '0; sxv_r <= '0; syu_r <= '0;
      sr_r <= '0;
    end else begin
      add_en_r <= cmd.acc_fire && (cnt_r < PAIR_CAP);
      if (cmd.acc_fire && (cnt_r < PAIR_CAP)) cnt_r <= cnt_r + 1'b1;
      if (add_en_r) begin
        sx_r  <= sx_r + SUM_W'(p_x_r);
        sy_r  <= sy_r + SUM_W'(p_y_r);
        su_r  <= su_r + SUM_W'(p_u_r);
        sv_r  <= sv_r + SUM_W'(p_v_r);
        sxu_r <= sxu_r + XP_W'(p_xu_r);
        syv_r <= syv_r + XP_W'(p_yv_r);
        sxv_r <= sxv_r + XP_W'(p_xv_r);
        syu_r <= syu_r + XP_W'(p_yu_r);
        sr_r  <= sr_r + RAD_W'(p_rr_r);
      end
    end
  end

  // shared multipliers for the solve
  assign n_s = $signed({1'b0, cnt_r});

  always_comb begin
    sm_op     = '0;
    bg_a      = '0;
    bg_b      = '0;
    sh_val    = '0;
    use_small = 1'b0;
    use_shift = 1'b0;
    unique case (cmd.psel)
      P_N_SR: begin
        use_small = 1'b1;
        sm_op = (RAD_W+1)'(sr_r);
      end
      P_N_XUYV: begin
        use_small = 1'b1;
        sm_op = (RAD_W+1)'(sxu_r) + (RAD_W+1)'(syv_r);
      end
      P_N_XVYU: begin
        use_small = 1'b1;
        sm_op = (RAD_W+1)'(sxv_r) - (RAD_W+1)'(syu_r);
      end
      P_SX_SX: begin bg_a = (RES_W+1)'(sx_r); bg_b = (RES_W+1)'(sx_r); end
      P_SY_SY: begin bg_a = (RES_W+1)'(sy_r); bg_b = (RES_W+1)'(sy_r); end
      P_SX_SU: begin bg_a = (RES_W+1)'(sx_r); bg_b = (RES_W+1)'(su_r); end
      P_SY_SV: begin bg_a = (RES_W+1)'(sy_r); bg_b = (RES_W+1)'(sv_r); end
      P_SY_SU: begin bg_a = (RES_W+1)'(sy_r); bg_b = (RES_W+1)'(su_r); end
      P_SX_SV: begin bg_a = (RES_W+1)'(sx_r); bg_b = (RES_W+1)'(sv_r); end
      P_A_SX:  begin bg_a = (RES_W+1)'(a_r);  bg_b = (RES_W+1)'(sx_r); end
      P_B_SY:  begin bg_a = (RES_W+1)'(b_r);  bg_b = (RES_W+1)'(sy_r); end
      P_A_SY:  begin bg_a = (RES_W+1)'(a_r);  bg_b = (RES_W+1)'(sy_r); end
      P_B_SX:  begin bg_a = (RES_W+1)'(b_r);  bg_b = (RES_W+1)'(sx_r); end
      P_SU_SH: begin use_shift = 1'b1; sh_val = WRK_W'(su_r) <<< 16; end
      P_SV_SH: begin use_shift = 1'b1; sh_val = WRK_W'(sv_r) <<< 16; end
      P_NONE:  begin end
    endcase
  end

  assign sm_prod = sm_op * n_s;
  assign bg_prod = bg_a * bg_b;

  always_comb begin
    if (use_small) prod_nxt = WRK_W'(sm_prod);
    else if (use_shift) prod_nxt = sh_val;
    else prod_nxt = bg_prod[WRK_W-1:0];
  end

  always_comb begin
    unique case (pend_dst_r)
      W_DEN: wr_old = den_r;
      W_NA:  wr_old = na_r;
      W_NB:  wr_old = nb_r;
      W_T:   wr_old = t_r;
    endcase
    unique case (pend_op_r)
      OP_LOAD: wr_val = prod_r;
      OP_ADD:  wr_val = wr_old + prod_r;
      OP_SUB:  wr_val = wr_old - prod_r;
      OP_NONE: wr_val = wr_old;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_op_r <= OP_NONE;
    end else begin
      pend_op_r <= cmd.mul ? cmd.op : OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    pend_dst_r <= cmd.dst;
    unique case (pend_dst_r)
      W_DEN: den_r <= wr_val;
      W_NA:  na_r  <= wr_val;
      W_NB:  nb_r  <= wr_val;
      W_T:   t_r   <= wr_val;
    endcase
    if (cmd.chk) degen_r <= (den_r == '0);
    if (cmd.div_start) dsel_r <= cmd.dsel;
    if (d_done) begin
      unique case (dsel_r)
        D_A:  a_r  <= d_quo;
        D_B:  b_r  <= d_quo;
        D_TX: tx_r <= d_quo;
        D_TY: ty_r <= d_quo;
      endcase
    end
  end

  // divider operands
  always_comb begin
    unique case (cmd.dsel)
      D_A:  begin d_num = na_r; d_frac16 = 1'b1; end
      D_B:  begin d_num = nb_r; d_frac16 = 1'b1; end
      D_TX: begin d_num = t_r;  d_frac16 = 1'b0; end
      D_TY: begin d_num = t_r;  d_frac16 = 1'b0; end
    endcase
    if (d_frac16) d_den = den_r;
    else d_den = $signed({(WRK_W-CNT_W-12)'(0), cnt_r, 12'd0});
  end

  spls_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .frac16 (d_frac16),
    .num    (d_num),
    .den    (d_den),
    .done   (d_done),
    .quo    (d_quo)
  );

  assign sts.den_zero = (den_r == '0);
  assign sts.div_done = d_done;

  assign res_scale_cos  = degen_r ? '0 : a_r;
  assign res_scale_sin  = degen_r ? '0 : b_r;
  assign res_shift_x    = degen_r ? '0 : tx_r;
  assign res_shift_y    = degen_r ? '0 : ty_r;
  assign res_degenerate = degen_r;
  assign res_pairs_used = cnt_r;

endmodule

// ===== hw/rtl/spls_ctrl.sv =====
// ----------------------------------------------------------------------------
// spls_ctrl
// Controller: accumulate phase, solve sequence, divider waits, result beat.
// ----------------------------------------------------------------------------
module spls_ctrl import spls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uop_t            uop;

  assign uop = ucode(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_ACC: begin
        if (in_valid && in_last) state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        state_nxt = S_RUN;
        pc_nxt    = '0;
      end
      S_RUN: begin
        unique case (uop.kind)
          K_MUL: pc_nxt = pc_r + 1'b1;
          K_CHECK: begin
            if (sts.den_zero) state_nxt = S_OUT;
            else pc_nxt = pc_r + 1'b1;
          end
          K_DIV: state_nxt = S_DIV;
          K_END: state_nxt = S_OUT;
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RUN;
          pc_nxt    = pc_r + 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_ACC;
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == S_ACC);
    out_valid     = (state_r == S_OUT);
    cmd.acc_fire  = in_valid && (state_r == S_ACC);
    cmd.clear     = out_ready && (state_r == S_OUT);
    cmd.mul       = (state_r == S_RUN) && (uop.kind == K_MUL);
    cmd.psel      = uop.psel;
    cmd.op        = uop.op;
    cmd.dst       = uop.dst;
    cmd.div_start = (state_r == S_RUN) && (uop.kind == K_DIV);
    cmd.dsel      = uop.dsel;
    cmd.chk       = (state_r == S_RUN) && (uop.kind == K_CHECK);
  end

endmodule

// ===== hw/rtl/similarity_pose_least_squares.sv =====
// ----------------------------------------------------------------------------
// similarity_pose_least_squares
// Least-squares 2-D similarity pose fit over a stream of point pairs.
// ----------------------------------------------------------------------------
// Input channel (in_*): one beat per model/target point pair, Q12.4. Pairs
// are summed at one per cycle; pairs past 1024 are dropped. The beat with
// in_last_pair set closes the set.
// After that beat in_ready stays low while the solve runs: the sequencing
// steps plus four passes through the radix-2 divider, up to out_valid;
// a degenerate set skips the divides and goes straight to out_valid.
// Output channel (out_*): one beat per set with alpha, beta (Q16.16),
// tx, ty (Q24.8), degenerate and the pair count. The beat holds until
// out_ready; on that handshake the sums clear and in_ready returns.
// Reset (rst_n low, synchronous) clears the sums and the pair count and
// returns the block to accepting pairs.
// ----------------------------------------------------------------------------
module similarity_pose_least_squares import spls_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_model_x,
  input  logic signed [COORD_W-1:0] in_model_y,
  input  logic signed [COORD_W-1:0] in_target_x,
  input  logic signed [COORD_W-1:0] in_target_y,
  input  logic                      in_last_pair,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [RES_W-1:0]   out_scale_cos,
  output logic signed [RES_W-1:0]   out_scale_sin,
  output logic signed [RES_W-1:0]   out_shift_x,
  output logic signed [RES_W-1:0]   out_shift_y,
  output logic                      out_degenerate,
  output logic [CNT_W-1:0]          out_pairs_used
);

  cmd_t cmd;
  sts_t sts;

  spls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_pair),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spls_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_model_x     (in_model_x),
    .in_model_y     (in_model_y),
    .in_target_x    (in_target_x),
    .in_target_y    (in_target_y),
    .sts            (sts),
    .res_scale_cos  (out_scale_cos),
    .res_scale_sin  (out_scale_sin),
    .res_shift_x    (out_shift_x),
    .res_shift_y    (out_shift_y),
    .res_degenerate (out_degenerate),
    .res_pairs_used (out_pairs_used)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams point pairs into the similarity pose fit with random gaps and
// output stalls, predicts each set's pose in 64-bit integer math and
// compares every result beat field by field in a small scoreboard.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [31:0] scale_cos;
  logic signed [31:0] scale_sin;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic               degenerate;
  logic [10:0]        pairs_used;
} pose_t;

class pose_scoreboard;
  longint sum_x, sum_y, sum_u, sum_v, sum_xu, sum_yv, sum_xv, sum_yu, sum_rr;
  int     count;
  pose_t  pose_q[$];
  int     errors;

  function new();
    clear_sums();
    errors = 0;
  endfunction

  function void clear_sums();
    sum_x = 0; sum_y = 0; sum_u = 0; sum_v = 0;
    sum_xu = 0; sum_yv = 0; sum_xv = 0; sum_yu = 0; sum_rr = 0;
    count = 0;
  endfunction

  // round to nearest, ties away from zero, saturate to 32 bits
  function longint round_quot(longint num, longint den, int frac);
    bit        neg;
    bit [63:0] n, d, q, r;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (d == 0) return 0;
    q = n / d;
    r = n % d;
    if (q > (64'd1 << 32)) begin
      q = 64'd1 << 33;
    end else begin
      for (int i = 0; i <= frac; i++) begin
        q = q << 1;
        if (r >= d - r) begin
          q = q | 64'd1;
          r = r - (d - r);
        end else begin
          r = r + r;
        end
      end
      q = (q + 64'd1) >> 1;
    end
    if (neg) begin
      if (q >= (64'd1 << 31)) return -64'sd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) return 64'sd2147483647;
    return longint'(q);
  endfunction

  function void note_pair(logic signed [15:0] mx, logic signed [15:0] my,
                          logic signed [15:0] tx, logic signed [15:0] ty,
                          logic last);
    longint x, y, u, v, n, den, na, nb, a, b, t;
    pose_t  p;
    x = mx; y = my; u = tx; v = ty;
    if (count < 1024) begin
      sum_x += x; sum_y += y; sum_u += u; sum_v += v;
      sum_xu += x * u; sum_yv += y * v; sum_xv += x * v; sum_yu += y * u;
      sum_rr += x * x + y * y;
      count++;
    end
    if (!last) return;
    n = count;
    den = n * sum_rr - sum_x * sum_x - sum_y * sum_y;
    p.degenerate = (den == 0);
    p.pairs_used = count[10:0];
    p.scale_cos = 0; p.scale_sin = 0; p.shift_x = 0; p.shift_y = 0;
    if (den != 0) begin
      na = n * (sum_xu + sum_yv) - sum_x * sum_u - sum_y * sum_v;
      nb = n * (sum_xv - sum_yu) + sum_y * sum_u - sum_x * sum_v;
      a = round_quot(na, den, 16);
      b = round_quot(nb, den, 16);
      p.scale_cos = a[31:0];
      p.scale_sin = b[31:0];
      t = sum_u * 65536 - a * sum_x + b * sum_y;
      p.shift_x = 32'(round_quot(t, n * 4096, 0));
      t = sum_v * 65536 - a * sum_y - b * sum_x;
      p.shift_y = 32'(round_quot(t, n * 4096, 0));
    end
    pose_q.push_back(p);
    clear_sums();
  endfunction

  function void check_pose(pose_t got);
    pose_t exp_p;
    if (pose_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: cos=%0d sin=%0d", got.scale_cos,
                                 got.scale_sin);
      return;
    end
    exp_p = pose_q.pop_front();
    if (got.scale_cos !== exp_p.scale_cos || got.scale_sin !== exp_p.scale_sin ||
        got.shift_x !== exp_p.shift_x || got.shift_y !== exp_p.shift_y ||
        got.degenerate !== exp_p.degenerate || got.pairs_used !== exp_p.pairs_used) begin
      errors++;
      if (errors <= 10) begin
        $display("pose mismatch exp: %0d %0d %0d %0d deg=%0d n=%0d",
                 exp_p.scale_cos, exp_p.scale_sin, exp_p.shift_x, exp_p.shift_y,
                 exp_p.degenerate, exp_p.pairs_used);
        $display("pose mismatch got: %0d %0d %0d %0d deg=%0d n=%0d",
                 got.scale_cos, got.scale_sin, got.shift_x, got.shift_y,
                 got.degenerate, got.pairs_used);
      end
    end
  endfunction

  function int pending();
    return pose_q.size();
  endfunction
endclass

module testbench;
  import spls_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_model_x = '0;
  logic signed [COORD_W-1:0] in_model_y = '0;
  logic signed [COORD_W-1:0] in_target_x = '0;
  logic signed [COORD_W-1:0] in_target_y = '0;
  logic                      in_last_pair = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [RES_W-1:0]   out_scale_cos;
  logic signed [RES_W-1:0]   out_scale_sin;
  logic signed [RES_W-1:0]   out_shift_x;
  logic signed [RES_W-1:0]   out_shift_y;
  logic                      out_degenerate;
  logic [CNT_W-1:0]          out_pairs_used;

  pose_scoreboard sb = new();
  bit             steady = 1'b0;
  int             cycles = 0;

  similarity_pose_least_squares uut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL similarity_pose_least_squares");
      $finish;
    end
  end

  always @(posedge clk) begin
    pose_t got;
    if (rst_n && out_valid && out_ready) begin
      got.scale_cos = out_scale_cos;
      got.scale_sin = out_scale_sin;
      got.shift_x = out_shift_x;
      got.shift_y = out_shift_y;
      got.degenerate = out_degenerate;
      got.pairs_used = out_pairs_used;
      sb.check_pose(got);
    end
    out_ready <= rst_n && (steady || $urandom_range(99) >= 27);
  end

  task automatic send_pair(logic signed [15:0] mx, logic signed [15:0] my,
                           logic signed [15:0] tx, logic signed [15:0] ty, logic last);
    if (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_model_x <= mx;
    in_model_y <= my;
    in_target_x <= tx;
    in_target_y <= ty;
    in_last_pair <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(mx, my, tx, ty, last);
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // one set: fitted, fully random, or with all model points equal
  task automatic send_set(int size);
    int kind, c, s, ox, oy, x, y, px, py, jx, jy;
    kind = $urandom_range(9);
    c = $urandom_range(600) - 300;
    s = $urandom_range(600) - 300;
    ox = $urandom_range(8000) - 4000;
    oy = $urandom_range(8000) - 4000;
    px = $urandom_range(65535) - 32768;
    py = $urandom_range(65535) - 32768;
    for (int i = 0; i < size; i++) begin
      if (kind < 3) begin
        send_pair(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  i == size - 1);
      end else begin
        x = (kind == 9) ? px : $urandom_range(8000) - 4000;
        y = (kind == 9) ? py : $urandom_range(8000) - 4000;
        jx = $urandom_range(8) - 4;
        jy = $urandom_range(8) - 4;
        send_pair(clamp16(x), clamp16(y),
                  clamp16(((x * c - y * s) >>> 8) + ox + jx),
                  clamp16(((x * s + y * c) >>> 8) + oy + jy),
                  i == size - 1);
      end
    end
  endtask

  initial begin
    int sent;
    int size;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single pair always degenerate
    send_pair(16'sd100, -16'sd50, 16'sd7, 16'sd9, 1'b1);
    // all zero set
    send_pair(0, 0, 0, 0, 1'b0);
    send_pair(0, 0, 0, 0, 1'b1);
    // pure shift, identity rotation
    send_pair(16'sd16, 16'sd0, 16'sd48, 16'sd32, 1'b0);
    send_pair(-16'sd16, 16'sd32, 16'sd16, 16'sd64, 1'b1);
    // coordinate extremes, scale saturates
    send_pair(16'sd1, 16'sd0, 16'sd32767, -16'sd32768, 1'b0);
    send_pair(16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
    send_pair(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0);
    send_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1);
    // 180 degree rotation
    send_pair(16'sd32767, 16'sd0, -16'sd32767, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd32767, 16'sd0, -16'sd32767, 1'b0);
    send_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1);

    // hold off until the pipeline drains
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    sent = 0;
    while (sent < 437) begin
      steady = (sent >= 150 && sent < 230);
      size = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(10, 1);
      send_set(size);
      sent += size;
    end
    @(posedge clk);
    in_valid <= 1'b0;
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS similarity_pose_least_squares");
    end else begin
      $display("FAIL similarity_pose_least_squares");
    end
    $finish;
  end
endmodule
